// ===== rtl/altbl_pkg.sv =====
// Shared types, sizes and codes for the array list table engine.
// No dependencies; every other file refers to this package by scoped names.

package altbl_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W   = 32;
    localparam int ACT_W    = 2;
    localparam int ST_W     = 2;
    localparam int FIDX_W   = 4;
    localparam int ECNT_W   = 5;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SORTED = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage

// ===== rtl/altbl_ram.sv =====
// List store: one write port and one read port with registered read data.
// Depends on altbl_pkg for sizes and the request struct.

module altbl_ram
(
    input  logic                          clk,
    input  altbl_pkg::ram_req_t           req,
    output logic [altbl_pkg::DATA_W-1:0]  rdata
);

    logic [altbl_pkg::DATA_W-1:0] mem [altbl_pkg::CAPACITY];
    logic [altbl_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/altbl_cmp.sv =====
// Shared compare unit: equality and signed greater-than of a stored entry
// against the request value. Depends on altbl_pkg.

module altbl_cmp
(
    input  logic signed [altbl_pkg::DATA_W-1:0] entry,
    input  logic signed [altbl_pkg::DATA_W-1:0] value,
    output altbl_pkg::cmp_res_t                 res
);

    always_comb
    begin
        res.eq = (entry == value);
        res.gt = (entry > value);
    end

endmodule

// ===== rtl/altbl_ctrl.sv =====
// Sequencer for the list engine: walks the store one entry per cycle for
// shifts, searches and sorted inserts, and holds the result register.
// Depends on altbl_pkg.

module altbl_ctrl
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  logic [altbl_pkg::ACT_W-1:0]           action,
    input  logic signed [altbl_pkg::DATA_W-1:0]   value,
    input  logic [altbl_pkg::POS_W-1:0]           position,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output logic [altbl_pkg::ST_W-1:0]            status,
    output logic [altbl_pkg::FIDX_W-1:0]          found_index,
    output logic [altbl_pkg::ECNT_W-1:0]          entry_count,
    output altbl_pkg::ram_req_t                   ram_req,
    input  logic [altbl_pkg::DATA_W-1:0]          rdata,
    input  altbl_pkg::cmp_res_t                   cmp_res,
    output logic signed [altbl_pkg::DATA_W-1:0]   cmp_value
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP     = 3'd1;
    localparam logic [2:0] S_DOWN   = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_SORT   = 3'd4;
    localparam logic [2:0] S_PUT    = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;

    localparam logic [altbl_pkg::CNT_W-1:0] CNT_FULL = altbl_pkg::CNT_W'(altbl_pkg::CAPACITY);
    localparam logic [altbl_pkg::CNT_W-1:0] CNT_ONE  = altbl_pkg::CNT_W'(1);
    localparam logic [altbl_pkg::IDX_W-1:0] IDX_ONE  = altbl_pkg::IDX_W'(1);
    localparam logic [altbl_pkg::IDX_W-1:0] IDX_ZERO = '0;

    logic [2:0]                         state_reg, state_next;
    logic [altbl_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [altbl_pkg::IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [altbl_pkg::IDX_W-1:0]        slot_reg, slot_next;
    logic signed [altbl_pkg::DATA_W-1:0] value_reg, value_next;
    logic [altbl_pkg::ST_W-1:0]         st_reg, st_next;
    logic [altbl_pkg::IDX_W-1:0]        found_reg, found_next;

    logic                               rsp_valid_reg, rsp_valid_next;
    logic [altbl_pkg::ST_W-1:0]         rsp_status_reg, rsp_status_next;
    logic [altbl_pkg::FIDX_W-1:0]       rsp_found_reg, rsp_found_next;
    logic [altbl_pkg::ECNT_W-1:0]       rsp_count_reg, rsp_count_next;

    logic [altbl_pkg::CMP_W-1:0]        pos_ext, cnt_ext;
    logic [altbl_pkg::IDX_W-1:0]        last_idx;

    assign pos_ext  = altbl_pkg::CMP_W'(position);
    assign cnt_ext  = altbl_pkg::CMP_W'(cnt_reg);
    assign last_idx = altbl_pkg::IDX_W'(cnt_reg - CNT_ONE);

    assign req_ready   = (state_reg == S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign found_index = rsp_found_reg;
    assign entry_count = rsp_count_reg;
    assign cmp_value   = value_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_idx_next     = rd_idx_reg;
        slot_next       = slot_reg;
        value_next      = value_reg;
        st_next         = st_reg;
        found_next      = found_reg;
        rsp_valid_next  = rsp_valid_reg & ~rsp_ready;
        rsp_status_next = rsp_status_reg;
        rsp_found_next  = rsp_found_reg;
        rsp_count_next  = rsp_count_reg;
        ram_req.we      = 1'b0;
        ram_req.waddr   = rd_idx_reg;
        ram_req.wdata   = rdata;
        ram_req.raddr   = rd_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    value_next = value;
                    st_next    = altbl_pkg::ST_DONE;
                    found_next = IDX_ZERO;
                    case (action)
                        altbl_pkg::ACT_INSERT:
                        begin
                            if (cnt_reg == CNT_FULL)
                            begin
                                st_next    = altbl_pkg::ST_FULL;
                                state_next = S_RESP;
                            end
                            else if (pos_ext > cnt_ext)
                            begin
                                st_next    = altbl_pkg::ST_RANGE;
                                state_next = S_RESP;
                            end
                            else if (pos_ext == cnt_ext)
                            begin
                                slot_next  = altbl_pkg::IDX_W'(position);
                                state_next = S_PUT;
                            end
                            else
                            begin
                                slot_next     = altbl_pkg::IDX_W'(position);
                                ram_req.raddr = last_idx;
                                rd_idx_next   = last_idx;
                                state_next    = S_UP;
                            end
                        end
                        altbl_pkg::ACT_DELETE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                st_next    = altbl_pkg::ST_RANGE;
                                state_next = S_RESP;
                            end
                            else if (pos_ext + altbl_pkg::CMP_W'(1) == cnt_ext)
                            begin
                                cnt_next   = cnt_reg - CNT_ONE;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                ram_req.raddr = altbl_pkg::IDX_W'(position) + IDX_ONE;
                                rd_idx_next   = altbl_pkg::IDX_W'(position) + IDX_ONE;
                                state_next    = S_DOWN;
                            end
                        end
                        altbl_pkg::ACT_SEARCH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next    = altbl_pkg::ST_MISS;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                ram_req.raddr = IDX_ZERO;
                                rd_idx_next   = IDX_ZERO;
                                state_next    = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg == CNT_FULL)
                            begin
                                st_next    = altbl_pkg::ST_FULL;
                                state_next = S_RESP;
                            end
                            else if (cnt_reg == '0)
                            begin
                                slot_next  = IDX_ZERO;
                                state_next = S_PUT;
                            end
                            else
                            begin
                                ram_req.raddr = last_idx;
                                rd_idx_next   = last_idx;
                                state_next    = S_SORT;
                            end
                        end
                    endcase
                end
            end
            S_UP:
            begin
                // The entry read last cycle moves up by one place.
                ram_req.we    = 1'b1;
                ram_req.waddr = rd_idx_reg + IDX_ONE;
                if (rd_idx_reg == slot_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    ram_req.raddr = rd_idx_reg - IDX_ONE;
                    rd_idx_next   = rd_idx_reg - IDX_ONE;
                end
            end
            S_DOWN:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = rd_idx_reg - IDX_ONE;
                if (rd_idx_reg == last_idx)
                begin
                    cnt_next   = cnt_reg - CNT_ONE;
                    state_next = S_RESP;
                end
                else
                begin
                    ram_req.raddr = rd_idx_reg + IDX_ONE;
                    rd_idx_next   = rd_idx_reg + IDX_ONE;
                end
            end
            S_SEARCH:
            begin
                if (cmp_res.eq)
                begin
                    found_next = rd_idx_reg;
                    state_next = S_RESP;
                end
                else if (rd_idx_reg == last_idx)
                begin
                    st_next    = altbl_pkg::ST_MISS;
                    state_next = S_RESP;
                end
                else
                begin
                    ram_req.raddr = rd_idx_reg + IDX_ONE;
                    rd_idx_next   = rd_idx_reg + IDX_ONE;
                end
            end
            S_SORT:
            begin
                // Walk down from the top, moving larger entries up until an
                // entry that is not greater than the value is found.
                if (cmp_res.gt)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = rd_idx_reg + IDX_ONE;
                    if (rd_idx_reg == IDX_ZERO)
                    begin
                        slot_next  = IDX_ZERO;
                        state_next = S_PUT;
                    end
                    else
                    begin
                        ram_req.raddr = rd_idx_reg - IDX_ONE;
                        rd_idx_next   = rd_idx_reg - IDX_ONE;
                    end
                end
                else
                begin
                    slot_next  = rd_idx_reg + IDX_ONE;
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = slot_reg;
                ram_req.wdata = value_reg;
                cnt_next      = cnt_reg + CNT_ONE;
                state_next    = S_RESP;
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = st_reg;
                    rsp_found_next  = altbl_pkg::FIDX_W'(found_reg);
                    rsp_count_next  = altbl_pkg::ECNT_W'(cnt_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        slot_reg       <= slot_next;
        value_reg      <= value_next;
        st_reg         <= st_next;
        found_reg      <= found_next;
        rsp_status_reg <= rsp_status_next;
        rsp_found_reg  <= rsp_found_next;
        rsp_count_reg  <= rsp_count_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("entry count exceeds capacity");

    a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (altbl_pkg::CNT_W'(ram_req.waddr) <= cnt_reg))
        else $error("store write beyond the end of the list");

    a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) |=> (cnt_reg == $past(cnt_reg) + CNT_ONE))
        else $error("insert did not grow the list by one");

    a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_RESP))
        else $error("result raised outside the result state");

endmodule

// ===== rtl/array_list_table_engine.sv =====
// Top level of the array list table engine: sequencer, list store and
// shared compare unit. Depends on altbl_pkg, altbl_ram, altbl_cmp, altbl_ctrl.
//
//  Channel   Handshake              Payload
//  request   req_valid / req_ready  action, value, position
//  result    rsp_valid / rsp_ready  status, found_index, entry_count
//
// A request walks one store entry per cycle for as many entries as it needs,
// and an insert then writes the new entry; the single read and write port of
// the store, stepped once per cycle by the sequencer, sets this pace.
// Reset empties the list at once; the store contents are not cleared.
// A result waits in its output register while the next request is taken;
// a finished request holds until that register is free.

module array_list_table_engine
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  logic [altbl_pkg::ACT_W-1:0]          action,
    input  logic signed [altbl_pkg::DATA_W-1:0]  value,
    input  logic [altbl_pkg::POS_W-1:0]          position,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output logic [altbl_pkg::ST_W-1:0]           status,
    output logic [altbl_pkg::FIDX_W-1:0]         found_index,
    output logic [altbl_pkg::ECNT_W-1:0]         entry_count
);

    altbl_pkg::ram_req_t                 ram_req;
    altbl_pkg::cmp_res_t                 cmp_res;
    logic [altbl_pkg::DATA_W-1:0]        rdata;
    logic signed [altbl_pkg::DATA_W-1:0] cmp_value;

    altbl_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .action      (action),
        .value       (value),
        .position    (position),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .found_index (found_index),
        .entry_count (entry_count),
        .ram_req     (ram_req),
        .rdata       (rdata),
        .cmp_res     (cmp_res),
        .cmp_value   (cmp_value)
    );

    altbl_ram u_ram
    (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    altbl_cmp u_cmp
    (
        .entry (rdata),
        .value (cmp_value),
        .res   (cmp_res)
    );

endmodule

// ===== sim/array_list_table_engine_tb.sv =====
`timescale 1ns / 100ps
// Testbench for array_list_table_engine: directed and random list requests,
// with a shadow copy of the list that predicts every result in order.
// Depends on altbl_pkg and the engine RTL.

module array_list_table_engine_tb;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = altbl_pkg::CAPACITY + 8;
    localparam int RANDOM_ITEMS = 1315;

    localparam logic signed [altbl_pkg::DATA_W-1:0] MIN_VALUE = 32'sh8000_0000;
    localparam logic signed [altbl_pkg::DATA_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;

    typedef struct {
        logic [altbl_pkg::ST_W-1:0]   status;
        logic [altbl_pkg::FIDX_W-1:0] found_index;
        logic [altbl_pkg::ECNT_W-1:0] entry_count;
    } list_result_t;

    logic                                clk         = 1'b0;
    logic                                rst_n       = 1'b0;
    logic                                req_valid   = 1'b0;
    logic                                req_ready;
    logic [altbl_pkg::ACT_W-1:0]         action      = altbl_pkg::ACT_INSERT;
    logic signed [altbl_pkg::DATA_W-1:0] value       = '0;
    logic [altbl_pkg::POS_W-1:0]         position    = '0;
    logic                                rsp_valid;
    logic                                rsp_ready   = 1'b0;
    logic [altbl_pkg::ST_W-1:0]          status;
    logic [altbl_pkg::FIDX_W-1:0]        found_index;
    logic [altbl_pkg::ECNT_W-1:0]        entry_count;

    logic signed [altbl_pkg::DATA_W-1:0] shadow_entries [altbl_pkg::CAPACITY];
    int                                  shadow_count = 0;
    list_result_t                        pending_results [$];
    list_result_t                        oldest_result;
    int                                  error_count = 0;
    int                                  idle_cycles = 0;
    bit                                  quiet_sender = 1'b0;
    bit                                  quiet_receiver = 1'b0;

    array_list_table_engine u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .action      (action),
        .value       (value),
        .position    (position),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .found_index (found_index),
        .entry_count (entry_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void open_slot(int slot,
                                      logic signed [altbl_pkg::DATA_W-1:0] val);
        for (int i = shadow_count; i > slot; i--)
        begin
            shadow_entries[i] = shadow_entries[i - 1];
        end
        shadow_entries[slot] = val;
        shadow_count++;
    endfunction

    function automatic list_result_t predict_result(
        logic [altbl_pkg::ACT_W-1:0]         act,
        logic signed [altbl_pkg::DATA_W-1:0] val,
        logic [altbl_pkg::POS_W-1:0]         pos);
        list_result_t res;
        int           slot;
        res.status      = altbl_pkg::ST_DONE;
        res.found_index = '0;
        case (act)
            altbl_pkg::ACT_INSERT:
            begin
                // A full list is rejected before the position is looked at.
                if (shadow_count >= altbl_pkg::CAPACITY)
                    res.status = altbl_pkg::ST_FULL;
                else if (int'(pos) > shadow_count)
                    res.status = altbl_pkg::ST_RANGE;
                else
                    open_slot(int'(pos), val);
            end
            altbl_pkg::ACT_DELETE:
            begin
                if (int'(pos) >= shadow_count)
                    res.status = altbl_pkg::ST_RANGE;
                else
                begin
                    for (int i = int'(pos); i + 1 < shadow_count; i++)
                    begin
                        shadow_entries[i] = shadow_entries[i + 1];
                    end
                    shadow_count--;
                end
            end
            altbl_pkg::ACT_SEARCH:
            begin
                res.status = altbl_pkg::ST_MISS;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (res.status == altbl_pkg::ST_MISS && shadow_entries[i] == val)
                    begin
                        res.status      = altbl_pkg::ST_DONE;
                        res.found_index = altbl_pkg::FIDX_W'(i);
                    end
                end
            end
            default:
            begin
                if (shadow_count >= altbl_pkg::CAPACITY)
                    res.status = altbl_pkg::ST_FULL;
                else
                begin
                    // Walk down from the top past every entry greater than the value.
                    slot = shadow_count;
                    while (slot > 0 && shadow_entries[slot - 1] > val)
                        slot--;
                    open_slot(slot, val);
                end
            end
        endcase
        res.entry_count = altbl_pkg::ECNT_W'(shadow_count);
        return res;
    endfunction

    task automatic push_request(input logic [altbl_pkg::ACT_W-1:0] act,
                                input logic signed [altbl_pkg::DATA_W-1:0] val,
                                input logic [altbl_pkg::POS_W-1:0] pos);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        action    <= act;
        value     <= val;
        position  <= pos;
        do @(posedge clk); while (!req_ready);
        pending_results.push_back(predict_result(act, val, pos));
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: a random stall before each result, then ready until the transfer.
    initial
    begin : result_receiver
        int stall;
        forever
        begin
            stall = quiet_receiver ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                @(negedge clk);
                rsp_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no pending request: status %0d found_index %0d entry_count %0d",
                       status, found_index, entry_count);
                error_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (status !== oldest_result.status)
                begin
                    $error("status mismatch: expected %0d, got %0d",
                           oldest_result.status, status);
                    error_count++;
                end
                if (found_index !== oldest_result.found_index)
                begin
                    $error("found_index mismatch: expected %0d, got %0d",
                           oldest_result.found_index, found_index);
                    error_count++;
                end
                if (entry_count !== oldest_result.entry_count)
                begin
                    $error("entry_count mismatch: expected %0d, got %0d",
                           oldest_result.entry_count, entry_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic test_basic();
        push_request(altbl_pkg::ACT_SEARCH, 32'sd0, 5'd0);
        push_request(altbl_pkg::ACT_DELETE, 32'sd0, 5'd0);
        push_request(altbl_pkg::ACT_INSERT, 32'sd0, 5'd31);
        push_request(altbl_pkg::ACT_INSERT, MIN_VALUE, 5'd0);
        push_request(altbl_pkg::ACT_INSERT, MAX_VALUE, 5'd1);
        push_request(altbl_pkg::ACT_INSERT, -32'sd1, 5'd1);
        // The list is sorted here; the sorted insert still walks from the top.
        push_request(altbl_pkg::ACT_SORTED, 32'sd5, 5'd0);
        push_request(altbl_pkg::ACT_SEARCH, MAX_VALUE, 5'd0);
        push_request(altbl_pkg::ACT_DELETE, 32'sd0, 5'd3);
    endtask

    task automatic test_full_list();
        int k;
        k = 0;
        while (shadow_count < altbl_pkg::CAPACITY)
        begin
            push_request(altbl_pkg::ACT_SORTED, altbl_pkg::DATA_W'(k % 3) - 32'sd1, 5'd0);
            k++;
        end
        push_request(altbl_pkg::ACT_INSERT, 32'sd9, 5'd31);
        push_request(altbl_pkg::ACT_INSERT, 32'sd9, 5'd0);
        push_request(altbl_pkg::ACT_SORTED, MIN_VALUE, 5'd0);
        push_request(altbl_pkg::ACT_SEARCH, 32'sd1, 5'd0);
        push_request(altbl_pkg::ACT_DELETE, 32'sd0, 5'd16);
    endtask

    // The sender holds off until every outstanding result has come back.
    task automatic test_drain_pause();
        repeat (5)
            push_request(altbl_pkg::ACT_SEARCH,
                         altbl_pkg::DATA_W'($urandom_range(0, 2)) - 32'sd1, 5'd0);
        drain_results();
        repeat (5)
            push_request(altbl_pkg::ACT_DELETE, 32'sd0, 5'($urandom_range(0, 4)));
    endtask

    task automatic test_random(int n_items);
        logic [altbl_pkg::ACT_W-1:0]         act;
        logic signed [altbl_pkg::DATA_W-1:0] val;
        logic [altbl_pkg::POS_W-1:0]         pos;
        bit                                  growing;
        int                                  roll;
        int                                  pick;
        growing = 1'b1;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 100 == 0)
            begin
                quiet_sender   = ($urandom_range(0, 3) == 0);
                quiet_receiver = ($urandom_range(0, 3) == 0);
            end
            if (k % 150 == 149)
                drain_results();
            if (shadow_count >= altbl_pkg::CAPACITY)
                growing = 1'b0;
            else if (shadow_count == 0)
                growing = 1'b1;

            // Mostly small values and values already held, so searches hit and
            // duplicates pile up; now and then extremes and raw 32-bit words.
            pick = $urandom_range(0, 9);
            if (pick < 6)
                val = $urandom_range(0, 6) - 3;
            else if (pick < 8 && shadow_count > 0)
                val = shadow_entries[$urandom_range(0, shadow_count - 1)];
            else if (pick == 8)
                val = $urandom_range(0, 1) ? MAX_VALUE : MIN_VALUE;
            else
                val = $urandom;

            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                act = altbl_pkg::ACT_W'($urandom);
                pos = altbl_pkg::POS_W'($urandom);
                val = $urandom;
            end
            else
            begin
                roll = $urandom_range(0, 89);
                if (growing)
                    act = (roll < 35) ? altbl_pkg::ACT_INSERT :
                          (roll < 65) ? altbl_pkg::ACT_SORTED :
                          (roll < 80) ? altbl_pkg::ACT_SEARCH : altbl_pkg::ACT_DELETE;
                else
                    act = (roll < 50) ? altbl_pkg::ACT_DELETE :
                          (roll < 65) ? altbl_pkg::ACT_SEARCH :
                          (roll < 80) ? altbl_pkg::ACT_INSERT : altbl_pkg::ACT_SORTED;
                if ($urandom_range(0, 9) == 0)
                    pos = altbl_pkg::POS_W'($urandom);
                else if (act == altbl_pkg::ACT_DELETE)
                    pos = (shadow_count > 0) ?
                          altbl_pkg::POS_W'($urandom_range(0, shadow_count - 1)) : '0;
                else
                    pos = altbl_pkg::POS_W'($urandom_range(0, shadow_count));
            end
            push_request(act, val, pos);
        end
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        test_basic();
        test_full_list();
        test_drain_pause();
        test_random(RANDOM_ITEMS);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== array_list_table_engine.f =====
rtl/altbl_pkg.sv
rtl/altbl_ram.sv
rtl/altbl_cmp.sv
rtl/altbl_ctrl.sv
rtl/array_list_table_engine.sv
sim/array_list_table_engine_tb.sv
